/* hdl/bsm_pkg.sv */
// ----------------------------------------------------------------------------
// bsm_pkg: shared types and constants of the bounding sphere merge unit
// Field widths, arithmetic widths and the multiplier operand bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package bsm_pkg;

  // Field widths (Q16.16)
  localparam int unsigned CoordW = 32;
  localparam int unsigned RadW   = 31;

  // Shared multiplier: unsigned operands wide enough for |delta| (33 bits)
  localparam int unsigned MulW  = 33;
  localparam int unsigned ProdW = 2 * MulW;

  // Merge fraction is Q0.28, one bit above for the value one
  localparam int unsigned FracW = 28;
  localparam int unsigned QuoW  = FracW + 1;

  // Square root of a 66-bit sum: one result bit per step
  localparam int unsigned SqrtSteps = ProdW / 2;
  localparam int unsigned RootW     = SqrtSteps;
  localparam int unsigned RemW      = RootW + 3;

  localparam int unsigned CntW = $clog2(SqrtSteps);

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic        [RadW-1:0]   radius_t;

  localparam radius_t RadMax = {RadW{1'b1}};

  // Operand pair for the shared multiplier
  typedef struct packed {
    logic [MulW-1:0] a;
    logic [MulW-1:0] b;
  } mul_op_t;

endpackage

`default_nettype wire

/* hdl/bsm_if.sv */
// ----------------------------------------------------------------------------
// bsm_if: valid/ready channels of the bounding sphere merge unit
// bsm_in_if carries one input sphere, bsm_out_if one bound result.
// ----------------------------------------------------------------------------
`default_nettype none

interface bsm_in_if import bsm_pkg::*; ();
  logic    valid;
  logic    ready;
  logic    first;
  coord_t  sphere_x;
  coord_t  sphere_y;
  coord_t  sphere_z;
  radius_t sphere_radius;

  modport source (
    output valid, first, sphere_x, sphere_y, sphere_z, sphere_radius,
    input  ready
  );
  modport sink (
    input  valid, first, sphere_x, sphere_y, sphere_z, sphere_radius,
    output ready
  );
endinterface

interface bsm_out_if import bsm_pkg::*; ();
  logic    valid;
  logic    ready;
  coord_t  out_x;
  coord_t  out_y;
  coord_t  out_z;
  radius_t out_radius;

  modport source (
    output valid, out_x, out_y, out_z, out_radius,
    input  ready
  );
  modport sink (
    input  valid, out_x, out_y, out_z, out_radius,
    output ready
  );
endinterface

`default_nettype wire

/* hdl/bounding_sphere_merge_unit.sv */
// ----------------------------------------------------------------------------
// bounding_sphere_merge_unit: incremental bounding sphere union
// Grows a kept bound (Q16.16 center and radius) to enclose each input sphere
// and returns the bound after every merge.
// ----------------------------------------------------------------------------
// One sphere is taken at a time; the input is not ready while an item is in
// work. A merge that needs the enclosing sphere runs the squared distance and
// containment test on the shared multiplier, 33 square root steps and 29 divide
// steps on one shared shift-subtract unit, center shift on the multiplier, then
// radius update and result. A sphere that is copied or already contained goes
// to the result after the test, a zero-radius sphere goes there directly. The
// result sits in an output register, so the next sphere is taken while it waits.
// ----------------------------------------------------------------------------
`default_nettype none

module bounding_sphere_merge_unit import bsm_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  bsm_in_if.sink    sphere_i,
  bsm_out_if.source bound_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_SQZ,
    ST_SQG,
    ST_TEST,
    ST_SQRT,
    ST_PREP,
    ST_DIV,
    ST_SHX,
    ST_SHY,
    ST_SHZ,
    ST_SHW,
    ST_RAD,
    ST_DONE
  } state_e;

  state_e          state_q;

  // Kept bound and the sphere in work
  coord_t          bnd_x_q, bnd_y_q, bnd_z_q;
  radius_t         bnd_r_q;
  coord_t          n_x_q, n_y_q, n_z_q;
  radius_t         n_r_q;

  // Iteration registers
  logic [ProdW-1:0] s_q;
  logic [RemW-1:0]  rem_q;
  logic [RootW-1:0] root_q;
  logic [QuoW-1:0]  quo_q;
  logic             k0_q;
  logic [CntW-1:0]  cnt_q;

  // Output register
  logic            out_vld_q;
  coord_t          out_x_q, out_y_q, out_z_q;
  radius_t         out_r_q;

  mul_op_t          mul_op;
  logic [ProdW-1:0] prod;

  bsm_mul u_mul (
    .clk_i  (clk_i),
    .op_i   (mul_op),
    .prod_o (prod)
  );

  // Center deltas and their magnitudes
  logic signed [CoordW:0] dx, dy, dz;
  logic [MulW-1:0]        adx, ady, adz;
  logic signed [RadW:0]   rdiff;
  logic [RadW-1:0]        ardiff;

  always_comb begin
    dx = $signed({n_x_q[CoordW-1], n_x_q}) - $signed({bnd_x_q[CoordW-1], bnd_x_q});
    dy = $signed({n_y_q[CoordW-1], n_y_q}) - $signed({bnd_y_q[CoordW-1], bnd_y_q});
    dz = $signed({n_z_q[CoordW-1], n_z_q}) - $signed({bnd_z_q[CoordW-1], bnd_z_q});
    adx = dx[CoordW] ? MulW'(-dx) : MulW'(dx);
    ady = dy[CoordW] ? MulW'(-dy) : MulW'(dy);
    adz = dz[CoordW] ? MulW'(-dz) : MulW'(dz);
    rdiff  = $signed({1'b0, n_r_q}) - $signed({1'b0, bnd_r_q});
    ardiff = rdiff[RadW] ? RadW'(-rdiff) : RadW'(rdiff);
  end

  // Select multiplier operands
  always_comb begin
    mul_op = '0;
    case (state_q)
      ST_SQX:  mul_op = '{a: adx, b: adx};
      ST_SQY:  mul_op = '{a: ady, b: ady};
      ST_SQZ:  mul_op = '{a: adz, b: adz};
      ST_SQG:  mul_op = '{a: MulW'(ardiff), b: MulW'(ardiff)};
      ST_SHX:  mul_op = '{a: adx, b: MulW'(quo_q)};
      ST_SHY:  mul_op = '{a: ady, b: MulW'(quo_q)};
      ST_SHZ:  mul_op = '{a: adz, b: MulW'(quo_q)};
      default: mul_op = '0;
    endcase
  end

  // Shared shift-subtract unit: square root and divide steps
  logic [RemW-1:0] sub_a, sub_b;
  logic [RemW:0]   sub_diff;
  logic            sub_ok;

  always_comb begin
    if (state_q == ST_DIV) begin
      sub_a = {rem_q[RemW-2:0], k0_q};
      sub_b = {2'b00, root_q, 1'b0};
    end else begin
      sub_a = {rem_q[RemW-3:0], s_q[ProdW-1 -: 2]};
      sub_b = {1'b0, root_q, 2'b01};
    end
    sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
    sub_ok   = !sub_diff[RemW];
  end

  // Containment test and merge terms
  logic                    s_le_g, copy_new, keep_bnd;
  logic signed [RootW+1:0] k_d;
  logic                    div_go;
  logic [RootW+1:0]        rad_sum;
  logic [RootW:0]          rad_half;
  radius_t                 bnd_r_d;

  always_comb begin
    s_le_g   = s_q <= prod;
    copy_new = (bnd_r_q == '0) || ((n_r_q >= bnd_r_q) && s_le_g);
    keep_bnd = (bnd_r_q >= n_r_q) && s_le_g;
    k_d = $signed({2'b00, root_q}) + $signed({4'b0000, n_r_q})
        - $signed({4'b0000, bnd_r_q});
    div_go   = (root_q != '0) && !k_d[RootW+1] && (k_d != '0);
    rad_sum  = {2'b00, root_q} + (RootW+2)'(n_r_q) + (RootW+2)'(bnd_r_q);
    rad_half = rad_sum[RootW+1:1];
    bnd_r_d  = (rad_half > (RootW+1)'(RadMax)) ? RadMax : RadW'(rad_half);
  end

  // Move one center coordinate by the offset in the product, saturating
  function automatic coord_t shift_axis(coord_t b, logic neg, logic [ProdW-1:0] p);
    logic signed [CoordW+2:0] bext;
    logic signed [CoordW+2:0] off;
    logic signed [CoordW+2:0] sum;
    coord_t                   res;
    bext = {{3{b[CoordW-1]}}, b};
    off  = $signed({2'b00, p[FracW +: MulW]});
    sum  = neg ? bext - off : bext + off;
    if (sum > $signed({3'b000, {(CoordW-1){1'b1}}, 1'b1} >> 1)) begin
      res = {1'b0, {(CoordW-1){1'b1}}};
    end else if (sum < $signed({3'b111, 1'b1, {(CoordW-1){1'b0}}})) begin
      res = {1'b1, {(CoordW-1){1'b0}}};
    end else begin
      res = CoordW'(sum);
    end
    return res;
  endfunction

  logic in_xfer, out_xfer, out_free, out_load;

  assign in_xfer  = sphere_i.valid && sphere_i.ready;
  assign out_xfer = out_vld_q && bound_o.ready;
  assign out_free = !out_vld_q || bound_o.ready;
  assign out_load = (state_q == ST_DONE) && out_free;

  // Sequencer, bound and output registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      bnd_x_q   <= '0;
      bnd_y_q   <= '0;
      bnd_z_q   <= '0;
      bnd_r_q   <= '0;
      n_x_q     <= '0;
      n_y_q     <= '0;
      n_z_q     <= '0;
      n_r_q     <= '0;
      s_q       <= '0;
      rem_q     <= '0;
      root_q    <= '0;
      quo_q     <= '0;
      out_vld_q <= 1'b0;
      out_x_q   <= '0;
      out_y_q   <= '0;
      out_z_q   <= '0;
      out_r_q   <= '0;
      cnt_q     <= '0;
      k0_q      <= 1'b0;
    end else begin
      // Fill the output register or drop it after its transfer
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_xfer) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            n_x_q <= sphere_i.sphere_x;
            n_y_q <= sphere_i.sphere_y;
            n_z_q <= sphere_i.sphere_z;
            n_r_q <= sphere_i.sphere_radius;
            // Empty the bound on a first sphere
            if (sphere_i.first) begin
              bnd_x_q <= '0;
              bnd_y_q <= '0;
              bnd_z_q <= '0;
              bnd_r_q <= '0;
            end
            state_q <= (sphere_i.sphere_radius == '0) ? ST_DONE : ST_SQX;
          end
        end
        ST_SQX: state_q <= ST_SQY;
        ST_SQY: begin
          s_q     <= prod;
          state_q <= ST_SQZ;
        end
        ST_SQZ: begin
          s_q     <= s_q + prod;
          state_q <= ST_SQG;
        end
        ST_SQG: begin
          s_q     <= s_q + prod;
          state_q <= ST_TEST;
        end
        ST_TEST: begin
          rem_q  <= '0;
          root_q <= '0;
          cnt_q  <= CntW'(SqrtSteps - 1);
          if (copy_new) begin
            bnd_x_q <= n_x_q;
            bnd_y_q <= n_y_q;
            bnd_z_q <= n_z_q;
            bnd_r_q <= n_r_q;
            state_q <= ST_DONE;
          end else if (keep_bnd) begin
            state_q <= ST_DONE;
          end else begin
            state_q <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          // One root bit per step
          s_q    <= {s_q[ProdW-3:0], 2'b00};
          root_q <= {root_q[RootW-2:0], sub_ok};
          if (sub_ok) begin
            rem_q <= sub_diff[RemW-1:0];
          end else begin
            rem_q <= sub_a;
          end
          if (cnt_q == '0) begin
            state_q <= ST_PREP;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        ST_PREP: begin
          rem_q <= RemW'(k_d[RootW:1]);
          k0_q  <= k_d[0];
          quo_q <= '0;
          cnt_q <= CntW'(QuoW - 1);
          state_q <= div_go ? ST_DIV : ST_RAD;
        end
        ST_DIV: begin
          // One quotient bit per step against twice the distance
          k0_q  <= 1'b0;
          quo_q <= {quo_q[QuoW-2:0], sub_ok};
          if (sub_ok) begin
            rem_q <= sub_diff[RemW-1:0];
          end else begin
            rem_q <= sub_a;
          end
          if (cnt_q == '0) begin
            state_q <= ST_SHX;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        ST_SHX: state_q <= ST_SHY;
        ST_SHY: begin
          bnd_x_q <= shift_axis(bnd_x_q, dx[CoordW], prod);
          state_q <= ST_SHZ;
        end
        ST_SHZ: begin
          bnd_y_q <= shift_axis(bnd_y_q, dy[CoordW], prod);
          state_q <= ST_SHW;
        end
        ST_SHW: begin
          bnd_z_q <= shift_axis(bnd_z_q, dz[CoordW], prod);
          state_q <= ST_RAD;
        end
        ST_RAD: begin
          bnd_r_q <= bnd_r_d;
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          // Hold until the output register is free
          if (out_free) begin
            out_x_q   <= bnd_x_q;
            out_y_q   <= bnd_y_q;
            out_z_q   <= bnd_z_q;
            out_r_q   <= bnd_r_q;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign sphere_i.ready    = (state_q == ST_IDLE);
  assign bound_o.valid      = out_vld_q;
  assign bound_o.out_x      = out_x_q;
  assign bound_o.out_y      = out_y_q;
  assign bound_o.out_z      = out_z_q;
  assign bound_o.out_radius = out_r_q;

endmodule

`default_nettype wire

/* hdl/bsm_mul.sv */
// ----------------------------------------------------------------------------
// bsm_mul: shared unsigned multiplier
// One 33x33 product per cycle, registered; the sequencer picks the operands.
// ----------------------------------------------------------------------------
`default_nettype none

module bsm_mul import bsm_pkg::*; (
  input  wire logic             clk_i,
  input  wire mul_op_t          op_i,
  output      logic [ProdW-1:0] prod_o
);

  logic [ProdW-1:0] prod_q;

  // Register the product
  always_ff @(posedge clk_i) begin
    prod_q <= {{MulW{1'b0}}, op_i.a} * {{MulW{1'b0}}, op_i.b};
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

/* verif/bounding_sphere_merge_unit_tb.sv */
// ----------------------------------------------------------------------------
// bounding_sphere_merge_unit_tb: self-checking bench of the sphere merge unit
// Feeds spheres through the input channel with random gaps, predicts the
// bound after every transfer in a scoreboard and checks each result field by
// field, with random stalls and one long hold-off on the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module bounding_sphere_merge_unit_tb import bsm_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandomSpheres = 1850;
  localparam int unsigned DrainPoint    = 900;
  localparam int unsigned HoldOffAt     = 250;
  localparam int unsigned HoldOffCycles = 3000;
  localparam int unsigned SettleCycles  = 100;
  localparam int unsigned CycleLimit    = 1200000;

  typedef struct packed {
    logic    first;
    coord_t  x;
    coord_t  y;
    coord_t  z;
    radius_t radius;
  } sphere_item_t;

  typedef struct packed {
    coord_t  x;
    coord_t  y;
    coord_t  z;
    radius_t radius;
  } bound_t;

  // --------------------------------------------------------------------------
  // Scoreboard: tracks the enclosing sphere and holds the bounds still due
  // --------------------------------------------------------------------------
  class sphere_union_tracker;
    coord_t      cx, cy, cz;
    radius_t     cr;
    bound_t      pending_bounds[$];
    int unsigned mismatches;

    function new();
      cx = '0;
      cy = '0;
      cz = '0;
      cr = '0;
      mismatches = 0;
    endfunction

    function longint unsigned mag(longint d);
      return (d < 0) ? longint'(-d) : d;
    endfunction

    // True when a sphere of radius ri lies inside one of radius ro
    function bit encloses(longint ri, longint ro, logic [67:0] dist_sq);
      logic [67:0] gap_sq;
      if (ro < ri) return 1'b0;
      gap_sq = 68'(ro - ri) * 68'(ro - ri);
      return dist_sq <= gap_sq;
    endfunction

    // Floor square root, one result bit per step
    function longint unsigned floor_sqrt(logic [67:0] dist_sq);
      longint unsigned root;
      longint unsigned cand;
      root = 0;
      for (int b = 34; b >= 0; b--) begin
        cand = root | (64'd1 << b);
        if (72'(cand) * 72'(cand) <= 72'(dist_sq)) root = cand;
      end
      return root;
    endfunction

    function coord_t clamp_coord(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return coord_t'(v);
    endfunction

    // Move one axis by the merge fraction of its delta, toward zero rounding
    function coord_t shift_axis(coord_t base, longint delta, longint unsigned frac);
      longint unsigned offset;
      offset = (mag(delta) * frac) >> FracW;
      if (delta < 0) return clamp_coord(longint'(base) - longint'(offset));
      return clamp_coord(longint'(base) + longint'(offset));
    endfunction

    // Merge one sphere into the kept bound and return the new bound
    function bound_t merge_sphere(sphere_item_t s);
      longint          dx, dy, dz, nr, br, k, rad;
      longint unsigned center_dist, frac, ku;
      logic [67:0]     dist_sq;
      bound_t          res;
      if (s.first) begin
        cx = '0;
        cy = '0;
        cz = '0;
        cr = '0;
      end
      nr = s.radius;
      br = cr;
      if (nr != 0) begin
        dx = longint'(s.x) - longint'(cx);
        dy = longint'(s.y) - longint'(cy);
        dz = longint'(s.z) - longint'(cz);
        dist_sq = 68'(mag(dx)) * 68'(mag(dx)) + 68'(mag(dy)) * 68'(mag(dy))
                + 68'(mag(dz)) * 68'(mag(dz));
        if (br == 0 || encloses(br, nr, dist_sq)) begin
          // Copy the sphere over an empty or swallowed bound
          cx = s.x;
          cy = s.y;
          cz = s.z;
          cr = s.radius;
        end else if (!encloses(nr, br, dist_sq)) begin
          center_dist = floor_sqrt(dist_sq);
          k = longint'(center_dist) + nr - br;
          if (center_dist != 0 && k > 0) begin
            ku = k;
            frac = (ku << FracW) / (center_dist * 2);
            cx = shift_axis(cx, dx, frac);
            cy = shift_axis(cy, dy, frac);
            cz = shift_axis(cz, dz, frac);
          end
          rad = (br + nr + longint'(center_dist)) / 2;
          cr = (rad > longint'(RadMax)) ? RadMax : radius_t'(rad);
        end
      end
      res.x = cx;
      res.y = cy;
      res.z = cz;
      res.radius = cr;
      return res;
    endfunction

    function void note_sphere(sphere_item_t s);
      pending_bounds.push_back(merge_sphere(s));
    endfunction

    function void report_field(string name, longint want, longint got);
      if (want != got) begin
        mismatches++;
        $display("%0t: %s mismatch: expected %0d (0x%08h), actual %0d (0x%08h)",
                 $time, name, want, want[31:0], got, got[31:0]);
      end
    endfunction

    function void check_bound(bound_t got);
      bound_t want;
      if (pending_bounds.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected bound: expected none, actual x=%0d y=%0d z=%0d r=%0d",
                 $time, got.x, got.y, got.z, got.radius);
        return;
      end
      want = pending_bounds.pop_front();
      report_field("out_x", want.x, got.x);
      report_field("out_y", want.y, got.y);
      report_field("out_z", want.z, got.z);
      report_field("out_radius", want.radius, got.radius);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int unsigned cycles;
  int unsigned results_seen;
  bit          held_off;

  sphere_union_tracker tracker = new();

  bsm_in_if  sphere_if ();
  bsm_out_if bound_if ();

  bounding_sphere_merge_unit uut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .sphere_i (sphere_if),
    .bound_o  (bound_if)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("[bounding_sphere_merge_unit] ERROR");
      $finish;
    end
  end

  // Check every result transfer
  always @(posedge clk) begin
    if (rst_n && bound_if.valid && bound_if.ready) begin
      tracker.check_bound({bound_if.out_x, bound_if.out_y, bound_if.out_z,
                           bound_if.out_radius});
      results_seen++;
    end
  end

  // Mostly short gaps, some none, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 40) return 0;
    if (p < 85) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic sphere_item_t mk_sphere(logic first, coord_t x, coord_t y, coord_t z,
                                             radius_t r);
    sphere_item_t s;
    s.first = first;
    s.x = x;
    s.y = y;
    s.z = z;
    s.radius = r;
    return s;
  endfunction

  function automatic coord_t near_coord(coord_t c, int unsigned span);
    return c + coord_t'(int'($urandom_range(0, 2 * span)) - int'(span));
  endfunction

  // Random sphere: mostly spheres that interact with the bound
  function automatic sphere_item_t pick_sphere(logic first);
    sphere_item_t s;
    int unsigned  p;
    p = $urandom_range(0, 99);
    s.first = first;
    if (p < 45) begin
      s.x = near_coord('0, 32'h100000);
      s.y = near_coord('0, 32'h100000);
      s.z = near_coord('0, 32'h100000);
      s.radius = radius_t'($urandom_range(1, 32'h40000));
    end else if (p < 65) begin
      // Near the current bound: contained, touching or swallowing
      s.x = near_coord(tracker.cx, 32'h4000);
      s.y = near_coord(tracker.cy, 32'h4000);
      s.z = near_coord(tracker.cz, 32'h4000);
      if ($urandom_range(0, 1)) s.radius = tracker.cr + radius_t'($urandom_range(1, 32'h4000));
      else s.radius = radius_t'($urandom_range(1, 32'h10000));
    end else if (p < 72) begin
      s.x = $urandom;
      s.y = $urandom;
      s.z = $urandom;
      s.radius = '0;
    end else if (p < 92) begin
      s.x = $urandom;
      s.y = $urandom;
      s.z = $urandom;
      s.radius = radius_t'($urandom);
    end else begin
      // Far and huge: radius saturation
      s.x = $urandom;
      s.y = $urandom;
      s.z = $urandom;
      s.radius = radius_t'($urandom_range(32'h40000000, 32'h7FFFFFFF));
    end
    return s;
  endfunction

  // Offer one sphere and hold it until the transfer
  task automatic send_sphere(sphere_item_t s);
    sphere_if.valid         <= 1'b1;
    sphere_if.first         <= s.first;
    sphere_if.sphere_x      <= s.x;
    sphere_if.sphere_y      <= s.y;
    sphere_if.sphere_z      <= s.z;
    sphere_if.sphere_radius <= s.radius;
    do @(posedge clk); while (!sphere_if.ready);
    tracker.note_sphere(s);
  endtask

  // Idle the input between transfers, optionally until all bounds are back
  task automatic idle_input(bit drain);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0 || drain) begin
      sphere_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      if (drain) begin
        do @(posedge clk); while (tracker.pending_bounds.size() != 0);
      end
    end
  endtask

  // Result side: random stalls, one long hold-off once traffic is going
  initial begin
    bound_if.ready = 1'b0;
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      if (!held_off && results_seen >= HoldOffAt) begin
        bound_if.ready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk);
        held_off = 1'b1;
      end
      bound_if.ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      if (pick_gap() > 0) begin
        bound_if.ready <= 1'b0;
        repeat (pick_gap() + 1) @(posedge clk);
      end
    end
  end

  // Input side: reset, directed spheres, random runs, drain and verdict
  initial begin
    sphere_item_t directed[$];
    int unsigned  sent;
    int unsigned  run_len;
    logic         first;

    rst_n                   = 1'b0;
    sphere_if.valid         = 1'b0;
    sphere_if.first         = 1'b0;
    sphere_if.sphere_x      = '0;
    sphere_if.sphere_y      = '0;
    sphere_if.sphere_z      = '0;
    sphere_if.sphere_radius = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Copy into empty bound, contained, swallowing, skipped, cleared
    directed.push_back(mk_sphere(1'b1, '0, '0, '0, 31'h10000));
    directed.push_back(mk_sphere(1'b0, '0, '0, '0, 31'h8000));
    directed.push_back(mk_sphere(1'b0, '0, '0, '0, 31'h20000));
    directed.push_back(mk_sphere(1'b0, 32'sh1234, 32'sh5678, 32'sh9ABC, '0));
    directed.push_back(mk_sphere(1'b1, 32'sh7FFFFFFF, 32'sh80000000, '0, '0));
    // Extreme centers with the largest radius: saturated radius
    directed.push_back(mk_sphere(1'b0, 32'sh7FFFFFFF, 32'sh80000000, '0, RadMax));
    directed.push_back(mk_sphere(1'b0, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, RadMax));
    // Opposite corners, tiny radii
    directed.push_back(mk_sphere(1'b1, 32'sh80000000, 32'sh80000000, 32'sh80000000, 31'd1));
    directed.push_back(mk_sphere(1'b0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 31'd1));
    // Touching from inside counts as contained, both ways
    directed.push_back(mk_sphere(1'b1, '0, '0, '0, 31'h20000));
    directed.push_back(mk_sphere(1'b0, 32'sh10000, '0, '0, 31'h10000));
    directed.push_back(mk_sphere(1'b0, 32'sh10000, '0, '0, 31'h30000));
    // Plain merges in the x-y plane and off it
    directed.push_back(mk_sphere(1'b0, 32'sh0A0000, 32'sh10000, '0, 31'h10000));
    directed.push_back(mk_sphere(1'b0, '0, -32'sh0A0000, '0, 31'h18000));
    directed.push_back(mk_sphere(1'b0, -32'sh30000, 32'sh40000, -32'sh50000, 31'd1));
    // Externally touching spheres
    directed.push_back(mk_sphere(1'b1, '0, '0, '0, 31'h10000));
    directed.push_back(mk_sphere(1'b0, '0, '0, 32'sh20000, 31'h10000));
    // Clear a full bound with a zero-radius first sphere
    directed.push_back(mk_sphere(1'b1, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, '0));
    directed.push_back(mk_sphere(1'b0, -32'sh1, -32'sh1, -32'sh1, RadMax));
    directed.push_back(mk_sphere(1'b0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, RadMax));

    foreach (directed[i]) begin
      send_sphere(directed[i]);
      idle_input(1'b0);
    end

    // Random runs, each opened by a first sphere most of the time
    sent = 0;
    while (sent < RandomSpheres) begin
      run_len = $urandom_range(1, 24);
      for (int j = 0; j < run_len && sent < RandomSpheres; j++) begin
        if (j == 0) first = ($urandom_range(0, 9) != 0);
        else first = ($urandom_range(0, 39) == 0);
        send_sphere(pick_sphere(first));
        sent++;
        idle_input(sent == DrainPoint);
      end
    end

    // Let the last bounds come back, then settle
    sphere_if.valid <= 1'b0;
    while (tracker.pending_bounds.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending_bounds.size() == 0) begin
      $display("[bounding_sphere_merge_unit] OK");
    end else begin
      $display("[bounding_sphere_merge_unit] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* bounding_sphere_merge_unit.f */
hdl/bsm_pkg.sv
hdl/bsm_if.sv
hdl/bsm_mul.sv
hdl/bounding_sphere_merge_unit.sv
verif/bounding_sphere_merge_unit_tb.sv
